/* rtl/lcfe_pkg.sv */
// Shared constants, types and the sequencer microcode for the light command frame engine.
`default_nettype none

package lcfe_pkg;

    localparam int NUM_SLOTS_DEF = 13;

    localparam logic [7:0]  TICKS_PER_MS_RESET = 8'd156;
    localparam logic [15:0] TIMEOUT_MS_RESET   = 16'd100;

    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_N = 8'h4E;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 1'd1;

    localparam int SLOT_DATA_W = 40;
    localparam logic [2:0] FRAME_LAST_POS = 3'd7;
    localparam logic [2:0] READ_LAST_IDX  = 3'd6;

    // Sequencer step addresses.
    localparam logic [3:0] STEP_FETCH  = 4'd0;
    localparam logic [3:0] STEP_STORE  = 4'd1;
    localparam logic [3:0] STEP_DECODE = 4'd2;
    localparam logic [3:0] STEP_WCHK   = 4'd3;
    localparam logic [3:0] STEP_WRITE  = 4'd4;
    localparam logic [3:0] STEP_RCHK   = 4'd5;
    localparam logic [3:0] STEP_LOAD   = 4'd6;
    localparam logic [3:0] STEP_EMITB  = 4'd7;
    localparam logic [3:0] STEP_EMITS  = 4'd8;
    localparam logic [3:0] STEP_TICK   = 4'd9;
    localparam logic [3:0] STEP_MSCHK  = 4'd10;
    localparam logic [3:0] STEP_POSINC = 4'd11;
    localparam logic [3:0] STEP_NAK    = 4'd12;

    // Datapath actions.
    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_BUF_WR  = 4'd1;
    localparam logic [3:0] ACT_POS_INC = 4'd2;
    localparam logic [3:0] ACT_POS_CLR = 4'd3;
    localparam logic [3:0] ACT_MEM_WR  = 4'd4;
    localparam logic [3:0] ACT_LOAD    = 4'd5;
    localparam logic [3:0] ACT_SUM_ADD = 4'd6;
    localparam logic [3:0] ACT_TICK    = 4'd7;
    localparam logic [3:0] ACT_MS_CHK  = 4'd8;

    // Jump conditions.
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_TICK     = 3'd2;
    localparam logic [2:0] COND_POS_MORE = 3'd3;
    localparam logic [2:0] COND_NOT_W    = 3'd4;
    localparam logic [2:0] COND_W_REJ    = 3'd5;
    localparam logic [2:0] COND_R_REJ    = 3'd6;
    localparam logic [2:0] COND_RD_MORE  = 3'd7;

    // Response byte sources.
    localparam logic [1:0] SRC_BUF = 2'd0;
    localparam logic [1:0] SRC_SUM = 2'd1;
    localparam logic [1:0] SRC_ACK = 2'd2;
    localparam logic [1:0] SRC_NAK = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       emit;
        logic [1:0] src;
        logic       last;
        logic [3:0] act;
        logic [2:0] cond;
        logic [3:0] target;
    } ucode_t;

    typedef struct packed {
        logic                   en;
        logic [7:0]             slot;
        logic [SLOT_DATA_W-1:0] data;
    } slot_wr_t;

    function automatic ucode_t ucode_rom(input logic [3:0] pc);
        ucode_t w;
        w = '{accept: 1'b0, emit: 1'b0, src: SRC_BUF, last: 1'b0,
              act: ACT_NONE, cond: COND_ALWAYS, target: STEP_FETCH};
        case (pc)
            STEP_FETCH:
            begin
                w.accept = 1'b1;
                w.cond   = COND_TICK;
                w.target = STEP_TICK;
            end
            STEP_STORE:
            begin
                w.act    = ACT_BUF_WR;
                w.cond   = COND_POS_MORE;
                w.target = STEP_POSINC;
            end
            STEP_DECODE:
            begin
                w.act    = ACT_POS_CLR;
                w.cond   = COND_NOT_W;
                w.target = STEP_RCHK;
            end
            STEP_WCHK:
            begin
                w.cond   = COND_W_REJ;
                w.target = STEP_NAK;
            end
            STEP_WRITE:
            begin
                w.emit = 1'b1;
                w.src  = SRC_ACK;
                w.last = 1'b1;
                w.act  = ACT_MEM_WR;
            end
            STEP_RCHK:
            begin
                w.cond   = COND_R_REJ;
                w.target = STEP_NAK;
            end
            STEP_LOAD:
            begin
                w.act  = ACT_LOAD;
                w.cond = COND_NEVER;
            end
            STEP_EMITB:
            begin
                w.emit   = 1'b1;
                w.src    = SRC_BUF;
                w.act    = ACT_SUM_ADD;
                w.cond   = COND_RD_MORE;
                w.target = STEP_EMITB;
            end
            STEP_EMITS:
            begin
                w.emit = 1'b1;
                w.src  = SRC_SUM;
                w.last = 1'b1;
            end
            STEP_TICK:
            begin
                w.act  = ACT_TICK;
                w.cond = COND_NEVER;
            end
            STEP_MSCHK:
            begin
                w.act = ACT_MS_CHK;
            end
            STEP_POSINC:
            begin
                w.act = ACT_POS_INC;
            end
            STEP_NAK:
            begin
                w.emit = 1'b1;
                w.src  = SRC_NAK;
                w.last = 1'b1;
            end
            default:
            begin
                w.cond = COND_ALWAYS;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/lcfe_req_if.sv */
// Input channel: received bytes and timer ticks.
`default_nettype none

interface lcfe_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, operation, rx_byte, input ready);
    modport sink (input valid, operation, rx_byte, output ready);
    modport monitor (input valid, ready, operation, rx_byte);
endinterface

`default_nettype wire

/* rtl/lcfe_rsp_if.sv */
// Output channel: response bytes.
`default_nettype none

interface lcfe_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, tx_byte, last, input ready);
    modport sink (input valid, tx_byte, last, output ready);
    modport monitor (input valid, ready, tx_byte, last);
endinterface

`default_nettype wire

/* rtl/lcfe_slot_store.sv */
// Slot store: color memory with per-slot valid bits and a registered read port.
`default_nettype none

module lcfe_slot_store
    import lcfe_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire slot_wr_t               wr,
    input  wire logic [7:0]             rd_slot,
    output logic      [SLOT_DATA_W-1:0] rd_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    logic [SLOT_DATA_W-1:0] mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   valid_reg;
    logic [SLOT_DATA_W-1:0] rd_mem_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.slot[SLOT_W-1:0]] <= wr.data;
        end
        rd_mem_reg <= mem[rd_slot[SLOT_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.slot[SLOT_W-1:0]] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_slot[SLOT_W-1:0]];
        end
    end

    // A slot never written since reset reads as zero.
    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

`default_nettype wire

/* rtl/light_command_frame_engine_unit.sv */
// Light command frame engine: top level with microcoded sequencer and datapath.
//
// The req channel carries one beat per received serial byte (operation 0)
// or per timer tick (operation 1). Eight byte beats form a command frame;
// a 'W' frame stores five color bytes in a slot and answers 'A', an 'R'
// frame answers eight beats (echo, slot, five stored bytes, checksum), and
// a rejected or unknown frame answers 'N'. The rsp channel flags the final
// beat of each response with last. Ticks feed a free-running divider that
// clears a partial frame when timeout_ms milliseconds have gone by.
// The sequencer handles one beat at a time: a byte that does not end a
// frame is stored and the position bumped, a tick steps the divider and
// timeout check, a frame end is decoded, checked and answered 'A' or 'N',
// and a read at one beat per cycle unless rsp stalls, by the single step loop.
// A response beat sits in an output register, so req is taken again as
// soon as the last beat is loaded; while rsp stalls, the sequencer waits
// on its next emit step and req stays low once it reaches one.
// Reset clears the frame position, divider, slot store and output valid at
// once; the block accepts beats from the first cycle after reset.
`default_nettype none

module light_command_frame_engine_unit
    import lcfe_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lcfe_req_if.sink                   req,
    lcfe_rsp_if.source                 rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [3:0]  pc_reg, pc_next;
    logic [2:0]  pos_reg, pos_next;
    logic [2:0]  k_reg, k_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  byte_reg;
    logic [7:0]  buf_reg [8];
    logic [7:0]  buf_next [8];
    logic [7:0]  tick_reg, tick_next;
    logic [15:0] ms_reg, ms_next;
    logic [7:0]  tpm_reg;
    logic [15:0] tmo_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    ucode_t                 uc;
    logic                   out_free;
    logic                   fire;
    logic                   cond_true;
    logic                   slot_bad;
    logic [7:0]             tick_inc;
    logic [7:0]             emit_byte;
    slot_wr_t               slot_wr;
    logic [SLOT_DATA_W-1:0] slot_rd;

    lcfe_slot_store #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (slot_wr),
        .rd_slot (buf_reg[1]),
        .rd_data (slot_rd)
    );

    assign uc       = ucode_rom(pc_reg);
    assign out_free = !out_valid_reg || rsp.ready;
    assign fire     = (!uc.accept || req.valid) && (!uc.emit || out_free);
    assign slot_bad = {1'b0, buf_reg[1]} >= 9'(NUM_SLOTS);
    assign tick_inc = tick_reg + 8'd1;

    assign req.ready   = uc.accept;
    assign rsp.valid   = out_valid_reg;
    assign rsp.tx_byte = out_byte_reg;
    assign rsp.last    = out_last_reg;

    assign slot_wr.en   = fire && (uc.act == ACT_MEM_WR);
    assign slot_wr.slot = buf_reg[1];
    assign slot_wr.data = {buf_reg[2], buf_reg[3], buf_reg[4], buf_reg[5], buf_reg[6]};

    always_comb
    begin
        case (uc.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_TICK:     cond_true = req.operation == OP_TICK;
            COND_POS_MORE: cond_true = pos_reg != FRAME_LAST_POS;
            COND_NOT_W:    cond_true = buf_reg[0] != CH_W;
            COND_W_REJ:    cond_true = slot_bad || (buf_reg[2] != 8'd0 && buf_reg[3] != 8'd0);
            COND_R_REJ:    cond_true = slot_bad || (buf_reg[0] != CH_R);
            COND_RD_MORE:  cond_true = k_reg != READ_LAST_IDX;
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        case (uc.src)
            SRC_BUF: emit_byte = buf_reg[k_reg];
            SRC_SUM: emit_byte = sum_reg;
            SRC_ACK: emit_byte = CH_A;
            SRC_NAK: emit_byte = CH_N;
            default: emit_byte = CH_N;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        pos_next  = pos_reg;
        k_next    = k_reg;
        sum_next  = sum_reg;
        tick_next = tick_reg;
        ms_next   = ms_reg;
        buf_next  = buf_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (fire)
        begin
            pc_next = cond_true ? uc.target : pc_reg + 4'd1;
            if (uc.emit)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = emit_byte;
                out_last_next  = uc.last;
            end
            case (uc.act)
                ACT_NONE:    ;
                ACT_BUF_WR:  buf_next[pos_reg] = byte_reg;
                ACT_POS_INC: pos_next = pos_reg + 3'd1;
                ACT_POS_CLR: pos_next = '0;
                ACT_MEM_WR:  ;
                ACT_LOAD:
                begin
                    buf_next[2] = slot_rd[39:32];
                    buf_next[3] = slot_rd[31:24];
                    buf_next[4] = slot_rd[23:16];
                    buf_next[5] = slot_rd[15:8];
                    buf_next[6] = slot_rd[7:0];
                    k_next      = '0;
                    sum_next    = '0;
                end
                ACT_SUM_ADD:
                begin
                    sum_next = sum_reg + buf_reg[k_reg];
                    k_next   = k_reg + 3'd1;
                end
                ACT_TICK:
                begin
                    if (tick_inc >= tpm_reg)
                    begin
                        tick_next = '0;
                        ms_next   = ms_reg + 16'd1;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                ACT_MS_CHK:
                begin
                    if (ms_reg >= tmo_reg)
                    begin
                        ms_next  = '0;
                        pos_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_FETCH;
            pos_reg       <= '0;
            tick_reg      <= '0;
            ms_reg        <= '0;
            out_valid_reg <= 1'b0;
            tpm_reg       <= TICKS_PER_MS_RESET;
            tmo_reg       <= TIMEOUT_MS_RESET;
        end
        else
        begin
            pc_reg        <= pc_next;
            pos_reg       <= pos_next;
            tick_reg      <= tick_next;
            ms_reg        <= ms_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TICKS_PER_MS: tpm_reg <= cfg_data[7:0];
                    REG_TIMEOUT_MS:   tmo_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        sum_reg      <= sum_next;
        buf_reg      <= buf_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (uc.accept && req.valid)
        begin
            byte_reg <= req.rx_byte;
        end
    end

endmodule

`default_nettype wire

/* rtl/lcfe_checker.sv */
// Port-level checker for the light command frame engine, bound to the top level.
`default_nettype none

module lcfe_checker
    import lcfe_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       req_operation,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [7:0] rsp_tx_byte,
    input wire logic       rsp_last
);

    // A stalled response beat holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last))
        else $error("stalled response beat changed");

    // No new beat is taken while a read response is still partly delivered.
    a_no_req_mid_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
        else $error("request taken in the middle of a response");

    // A timer tick never produces a response beat.
    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_operation == OP_TICK && !rsp_valid |=> !rsp_valid)
        else $error("response beat after a timer tick");

    // Reset leaves no response pending.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

endmodule

bind light_command_frame_engine_unit lcfe_checker u_lcfe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_operation (req.operation),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_tx_byte   (rsp.tx_byte),
    .rsp_last      (rsp.last)
);

`default_nettype wire

/* tb/light_command_frame_engine_unit_tb.sv */
// Self-checking testbench for the light command frame engine: random frames, ticks and stalls.
`default_nettype none

module light_command_frame_engine_unit_tb;
    import lcfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 300;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } req_beat_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } rsp_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lcfe_req_if req_ch();
    lcfe_rsp_if rsp_ch();

    light_command_frame_engine_unit #(
        .NUM_SLOTS (NUM_SLOTS_DEF)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Shadow state of the engine.
    logic [7:0]  frame_buf [8];
    logic [2:0]  frame_pos;
    logic [7:0]  slot_mem [NUM_SLOTS_DEF][5];
    logic [7:0]  tick_cnt;
    logic [15:0] ms_cnt;
    logic [7:0]  ticks_per_ms_cfg;
    logic [15:0] timeout_ms_cfg;

    req_beat_t req_backlog[$];
    rsp_beat_t resp_bytes_due[$];
    int        beats_queued;
    int        beats_taken;
    int        mismatch_count;
    logic      handed_over;
    int        burst_left;
    int        gap_left;
    logic      hold_armed;
    int        hold_left;
    int        stall_mode;
    int        mode_left;

    task automatic push_response(input logic [7:0] value, input logic fin);
        rsp_beat_t beat;
        beat.tx_byte = value;
        beat.last    = fin;
        resp_bytes_due.push_back(beat);
    endtask

    task automatic execute_frame();
        logic [7:0] sum;
        logic       slot_bad;
        int         k;
        slot_bad = (frame_buf[1] >= NUM_SLOTS_DEF);
        if (frame_buf[0] == CH_W)
        begin
            if (slot_bad || (frame_buf[2] != 8'd0 && frame_buf[3] != 8'd0))
            begin
                push_response(CH_N, 1'b1);
            end
            else
            begin
                for (k = 0; k < 5; k++)
                begin
                    slot_mem[frame_buf[1]][k] = frame_buf[2 + k];
                end
                push_response(CH_A, 1'b1);
            end
        end
        else if (frame_buf[0] == CH_R && !slot_bad)
        begin
            for (k = 0; k < 5; k++)
            begin
                frame_buf[2 + k] = slot_mem[frame_buf[1]][k];
            end
            sum = 8'd0;
            for (k = 0; k < 7; k++)
            begin
                sum = sum + frame_buf[k];
                push_response(frame_buf[k], 1'b0);
            end
            push_response(sum, 1'b1);
        end
        else
        begin
            push_response(CH_N, 1'b1);
        end
    endtask

    task automatic apply_req_beat(input logic op, input logic [7:0] value);
        if (op == OP_TICK)
        begin
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= ticks_per_ms_cfg)
            begin
                tick_cnt = 8'd0;
                ms_cnt   = ms_cnt + 16'd1;
            end
            if (ms_cnt >= timeout_ms_cfg)
            begin
                ms_cnt    = 16'd0;
                frame_pos = 3'd0;
            end
        end
        else
        begin
            frame_buf[frame_pos] = value;
            if (frame_pos == FRAME_LAST_POS)
            begin
                frame_pos = 3'd0;
                execute_frame();
            end
            else
            begin
                frame_pos = frame_pos + 3'd1;
            end
        end
    endtask

    task automatic add_beat(input logic op, input logic [7:0] value);
        req_beat_t beat;
        beat.operation = op;
        beat.rx_byte   = value;
        req_backlog.push_back(beat);
        beats_queued++;
    endtask

    task automatic add_frame(input logic [63:0] bytes);
        int i;
        for (i = 7; i >= 0; i--)
        begin
            add_beat(OP_BYTE, bytes[i*8 +: 8]);
        end
    endtask

    task automatic add_ticks(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            add_beat(OP_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_command_frame();
        logic [7:0] f [8];
        int         pick;
        int         i;
        for (i = 0; i < 8; i++)
        begin
            f[i] = 8'($urandom_range(0, 255));
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            f[0] = CH_W;
        end
        else if (pick < 90)
        begin
            f[0] = CH_R;
        end
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            f[1] = 8'($urandom_range(0, NUM_SLOTS_DEF - 1));
        end
        else if (pick < 95)
        begin
            f[1] = 8'($urandom_range(NUM_SLOTS_DEF, 20));
        end
        else
        begin
            f[1] = 8'hFF;
        end
        case ($urandom_range(0, 3))
            0: f[2] = 8'd0;
            1: f[3] = 8'd0;
            2:
            begin
                f[2] = 8'd0;
                f[3] = 8'd0;
            end
            default:
            begin
                f[2] = 8'($urandom_range(1, 255));
                f[3] = 8'($urandom_range(1, 255));
            end
        endcase
        for (i = 0; i < 8; i++)
        begin
            add_beat(OP_BYTE, f[i]);
        end
    endtask

    task automatic add_broken_frame(input logic noisy, input int resync_ticks);
        logic [7:0] head;
        int         len;
        int         i;
        len  = noisy ? $urandom_range(1, 7) : 8;
        head = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1)
        begin
            head = ($urandom_range(0, 1) == 1) ? CH_W : CH_R;
        end
        for (i = 0; i < len; i++)
        begin
            add_beat(OP_BYTE, (i == 0) ? head : 8'($urandom_range(0, 255)));
            if (noisy && $urandom_range(0, 3) == 0)
            begin
                add_ticks(1);
            end
        end
        if (noisy)
        begin
            add_ticks(resync_ticks);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_TICKS_PER_MS)
        begin
            ticks_per_ms_cfg = value[7:0];
        end
        else
        begin
            timeout_ms_cfg = value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (beats_taken != beats_queued || resp_bytes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_random_phase(input logic [7:0] tpm, input logic [15:0] tmo,
                                    input int budget);
        int   resync_ticks;
        int   count;
        int   pick;
        int   n;
        logic noisy;
        write_reg(REG_TICKS_PER_MS, {8'd0, tpm});
        write_reg(REG_TIMEOUT_MS, tmo);
        resync_ticks = ((tpm == 8'd0) ? 1 : int'(tpm)) * ((tmo == 16'd0) ? 1 : int'(tmo)) + 1;
        noisy        = (resync_ticks <= 17);
        count        = 0;
        while (count < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                add_command_frame();
                count += 8;
            end
            else if (pick < 82)
            begin
                n = $urandom_range(1, 4);
                add_ticks(n);
                count += n;
            end
            else
            begin
                add_broken_frame(noisy, resync_ticks);
                count += 8;
            end
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            apply_req_beat(req_ch.operation, req_ch.rx_byte);
            beats_taken++;
            handed_over = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        req_beat_t beat;
        if (rst_n && (!req_ch.valid || handed_over))
        begin
            handed_over = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (req_backlog.size() == 0)
            begin
                req_ch.valid <= 1'b0;
            end
            else
            begin
                beat = req_backlog.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.operation <= beat.operation;
                req_ch.rx_byte   <= beat.rx_byte;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;
                if (burst_left == 0)
                begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_armed)
        begin
            hold_armed = 1'b0;
            hold_left  = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(10, 60);
            end
            mode_left--;
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        rsp_beat_t due;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (resp_bytes_due.size() == 0)
            begin
                $error("unexpected beat: tx_byte %02h last %0b", rsp_ch.tx_byte, rsp_ch.last);
                mismatch_count++;
            end
            else
            begin
                due = resp_bytes_due.pop_front();
                if (rsp_ch.tx_byte !== due.tx_byte)
                begin
                    $error("tx_byte: expected %02h, actual %02h", due.tx_byte, rsp_ch.tx_byte);
                    mismatch_count++;
                end
                if (rsp_ch.last !== due.last)
                begin
                    $error("last: expected %0b, actual %0b", due.last, rsp_ch.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("** light_command_frame_engine_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int i;
        int k;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_BYTE;
        req_ch.rx_byte   = 8'd0;
        rsp_ch.ready     = 1'b0;
        for (i = 0; i < 8; i++)
        begin
            frame_buf[i] = 8'd0;
        end
        for (i = 0; i < NUM_SLOTS_DEF; i++)
        begin
            for (k = 0; k < 5; k++)
            begin
                slot_mem[i][k] = 8'd0;
            end
        end
        frame_pos        = 3'd0;
        tick_cnt         = 8'd0;
        ms_cnt           = 16'd0;
        ticks_per_ms_cfg = TICKS_PER_MS_RESET;
        timeout_ms_cfg   = TIMEOUT_MS_RESET;
        beats_queued     = 0;
        beats_taken      = 0;
        mismatch_count   = 0;
        handed_over      = 1'b0;
        burst_left       = 0;
        gap_left         = 0;
        hold_armed       = 1'b0;
        hold_left        = 0;
        stall_mode       = 0;
        mode_left        = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Full-scale write to the top slot, its read-back, and a write with uv and white both set.
        add_frame({CH_W, 8'd12, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
        add_ticks(1);
        add_frame({CH_R, 8'd12, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
        add_frame({CH_W, 8'd0, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFF});
        wait_drained();

        run_random_phase(8'd0, 16'd0, 12);
        run_random_phase(8'd1, 16'd2, 12);
        run_random_phase(8'd3, 16'd1, 16);
        run_random_phase(8'd255, 16'd65535, 12);
        @(posedge clk);
        hold_armed = 1'b1;
        run_random_phase(8'd2, 16'd3, 24);

        if (mismatch_count == 0)
        begin
            $display("** light_command_frame_engine_unit: PASSED **");
        end
        else
        begin
            $display("** light_command_frame_engine_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
